// ===== hdl/crc16_command_framer_core_defines.svh =====
// Assertion macros for the CRC-16 command framer.
// Included by the top level only; expands to nothing under SYNTHESIS.
`ifndef CRC16_COMMAND_FRAMER_CORE_DEFINES_SVH
`define CRC16_COMMAND_FRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfr: same-cycle check failed");
`define CFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfr: next-cycle check failed");
`else
`define CFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/cfr_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte update.
// Used by every module of the command framer; depends on nothing.
package cfr_pkg;

	localparam int          QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'h1021;
	localparam logic [7:0]  START_BYTE      = 8'h02;

	localparam logic [2:0] ST_H0      = 3'd0;
	localparam logic [2:0] ST_LEN_LO  = 3'd1;
	localparam logic [2:0] ST_LEN_HI  = 3'd2;
	localparam logic [2:0] ST_HCRC_LO = 3'd3;
	localparam logic [2:0] ST_HCRC_HI = 3'd4;
	localparam logic [2:0] ST_DATA    = 3'd5;
	localparam logic [2:0] ST_DCRC_LO = 3'd6;
	localparam logic [2:0] ST_DCRC_HI = 3'd7;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] field;
		logic [15:0] crc;
		logic        start;
		logic        empty;
		logic        finish;
	} job_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctrl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/cfr_front.sv =====
// Front end: accepts payload words, classifies them and keeps the data CRC.
// Depends on cfr_pkg; feeds jobs to cfr_queue.
module cfr_front import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic [15:0] frame_length,
	output job_t        job
);

	logic [15:0] running_crc_q;
	logic [15:0] bytes_left_q;
	logic        in_frame_q;

	logic        start;
	logic        empty;
	logic        finish;
	logic [15:0] crc_next;

	always_comb begin
		start    = !in_frame_q;
		empty    = start && (frame_length == 16'd0);
		finish   = start ? (frame_length == 16'd1) : (bytes_left_q <= 16'd1);
		crc_next = crc_byte(start ? CRC_INIT : running_crc_q, data_byte);
		job.data   = data_byte;
		job.field  = frame_length + 16'd2;
		job.crc    = empty ? 16'h0000 : crc_next;
		job.start  = start;
		job.empty  = empty;
		job.finish = finish && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= CRC_INIT;
			bytes_left_q  <= 16'd0;
			in_frame_q    <= 1'b0;
		end else if (accept) begin
			if (empty || finish) begin
				running_crc_q <= CRC_INIT;
				bytes_left_q  <= 16'd0;
				in_frame_q    <= 1'b0;
			end else begin
				running_crc_q <= crc_next;
				bytes_left_q  <= start ? frame_length - 16'd1 : bytes_left_q - 16'd1;
				in_frame_q    <= 1'b1;
			end
		end
	end

endmodule

// ===== hdl/cfr_queue.sv =====
// Short job queue between the front and back ends of the framer.
// Depends on cfr_pkg for the job type.
module cfr_queue import cfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	output logic    space,
	input  logic    pop,
	output logic    head_valid,
	output job_t    head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign space      = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/cfr_back.sv =====
// Back end: expands each job into frame bytes and holds the output word.
// Depends on cfr_pkg; takes jobs from cfr_queue.
module cfr_back import cfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head_job,
	input  logic       head_valid,
	output q_ctrl_t    ctrl,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	logic [2:0]  step_q;
	logic [15:0] hcrc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_end_q;

	logic [2:0]  cur_step;
	logic [2:0]  next_step;
	logic [7:0]  sel_byte;
	logic        sel_last;
	logic        sel_end;
	logic        done;
	logic        load;

	always_comb begin
		cur_step  = (head_job.start || step_q != ST_H0) ? step_q : ST_DATA;
		next_step = cur_step + 3'd1;
		sel_byte  = 8'h00;
		sel_last  = 1'b0;
		sel_end   = 1'b0;
		done      = 1'b0;
		case (cur_step)
			ST_H0:      sel_byte = START_BYTE;
			ST_LEN_LO:  sel_byte = head_job.field[7:0];
			ST_LEN_HI:  sel_byte = head_job.field[15:8];
			ST_HCRC_LO: sel_byte = hcrc_q[7:0];
			ST_HCRC_HI: begin
				sel_byte  = hcrc_q[15:8];
				next_step = head_job.empty ? ST_DCRC_LO : ST_DATA;
			end
			ST_DATA: begin
				sel_byte = head_job.data;
				sel_last = !head_job.finish;
				done     = !head_job.finish;
			end
			ST_DCRC_LO: sel_byte = head_job.crc[7:0];
			ST_DCRC_HI: begin
				sel_byte = head_job.crc[15:8];
				sel_last = 1'b1;
				sel_end  = 1'b1;
				done     = 1'b1;
			end
			default: sel_byte = 8'h00;
		endcase
		load      = head_valid && (!out_valid_q || out_ready);
		ctrl.valid = head_valid;
		ctrl.pop   = load && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_H0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= done ? ST_H0 : next_step;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			out_last_q <= sel_last;
			out_end_q  <= sel_end;
			if (cur_step == ST_H0) begin
				hcrc_q <= crc_byte(CRC_INIT, START_BYTE);
			end else if (cur_step == ST_LEN_LO || cur_step == ST_LEN_HI) begin
				hcrc_q <= crc_byte(hcrc_q, sel_byte);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_last_q;
	assign frame_end = out_end_q;

endmodule

// ===== hdl/crc16_command_framer_core.sv =====
// CRC-16 command framer: one payload word in, one framed byte per output word.
// A word inside a frame yields one output byte; the last payload word of a frame
// yields three (byte and data CRC), and a frame's first word yields six to eight
// (start byte, length field, header CRC, then byte and data CRC as they apply). The
// input side accepts one word per cycle while the job queue (QUEUE_DEPTH jobs) has
// room; the output register drains one byte per cycle while m_axis_tready is high.
// Header and data CRCs: CRC-16/CCITT-FALSE, low byte first; an empty frame sends 0000.
// Depends on cfr_pkg, cfr_front, cfr_queue, cfr_back and the assertion macros.
`include "crc16_command_framer_core_defines.svh"

module crc16_command_framer_core import cfr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] frame_length
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // [0] frame_end
);

	logic    accept;
	job_t    push_job;
	job_t    head_job;
	logic    q_space;
	logic    q_head_valid;
	q_ctrl_t q_ctrl;

	assign s_axis_tready = q_space;
	assign accept        = s_axis_tvalid && q_space;

	cfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (s_axis_tdata[7:0]),
		.frame_length (s_axis_tdata[23:8]),
		.job          (push_job)
	);

	cfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (push_job),
		.space      (q_space),
		.pop        (q_ctrl.pop),
		.head_valid (q_head_valid),
		.head_job   (head_job)
	);

	cfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (q_head_valid),
		.ctrl       (q_ctrl),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.frame_end  (m_axis_tuser)
	);

	`CFR_ASSERT_IMP(a_end_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`CFR_ASSERT_IMP(a_full_has_head, clk, arst_n, !s_axis_tready, q_ctrl.valid)
	`CFR_ASSERT_NXT(a_pop_loads_word, clk, arst_n, q_ctrl.pop, m_axis_tvalid)

endmodule

// ===== sim/tb_crc16_command_framer_core.sv =====
// Self-checking bench for crc16_command_framer_core: frames of random length and content go in,
// and every framed output word is compared with a local prediction of header, CRCs and payload.
// Depends on cfr_pkg (CRC constants, start byte) and the framer RTL.
module tb_crc16_command_framer_core;
	import cfr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic       fend;
	} framed_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	logic [23:0] pending_words[$];
	framed_t     due_bytes[$];
	logic        in_hs;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          errors;
	int          cycles;

	logic [15:0] pay_crc;
	logic [15:0] left_count;
	logic        framing;

	crc16_command_framer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // [7:0] data_byte, [23:8] frame_length
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // [7:0] out_byte
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)   // [0] frame_end
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	task automatic expect_byte(input logic [7:0] v, input logic last, input logic fend);
		due_bytes.push_back(framed_t'{octet: v, last: last, fend: fend});
	endtask

	task automatic frame_predict(input logic [23:0] w);
		logic [7:0]  b;
		logic [15:0] len;
		logic [15:0] field;
		logic [15:0] hc;
		logic        finish;
		b = w[7:0];
		len = w[23:8];
		finish = 1'b0;
		if (!framing) begin
			field = len + 16'd2;
			hc = crc16_step(CRC_INIT, START_BYTE);
			hc = crc16_step(hc, field[7:0]);
			hc = crc16_step(hc, field[15:8]);
			expect_byte(START_BYTE, 1'b0, 1'b0);
			expect_byte(field[7:0], 1'b0, 1'b0);
			expect_byte(field[15:8], 1'b0, 1'b0);
			expect_byte(hc[7:0], 1'b0, 1'b0);
			expect_byte(hc[15:8], 1'b0, 1'b0);
			if (len == 16'd0) begin
				expect_byte(8'h00, 1'b0, 1'b0);
				expect_byte(8'h00, 1'b1, 1'b1);
				pay_crc = CRC_INIT;
			end else begin
				pay_crc = crc16_step(CRC_INIT, b);
				if (len == 16'd1) begin
					expect_byte(b, 1'b0, 1'b0);
					finish = 1'b1;
				end else begin
					expect_byte(b, 1'b1, 1'b0);
					left_count = len - 16'd1;
					framing = 1'b1;
				end
			end
		end else begin
			pay_crc = crc16_step(pay_crc, b);
			if (left_count <= 16'd1) begin
				expect_byte(b, 1'b0, 1'b0);
				finish = 1'b1;
			end else begin
				expect_byte(b, 1'b1, 1'b0);
				left_count = left_count - 16'd1;
			end
		end
		if (finish) begin
			expect_byte(pay_crc[7:0], 1'b0, 1'b0);
			expect_byte(pay_crc[15:8], 1'b1, 1'b1);
			pay_crc = CRC_INIT;
			left_count = 16'd0;
			framing = 1'b0;
		end
	endtask

	// first word carries the length; later words carry noise in the length field
	task automatic queue_frame(input int len, input logic [7:0] first);
		logic [15:0] noise;
		logic [7:0]  b;
		pending_words.push_back({len[15:0], first});
		for (int i = 1; i < len; i++) begin
			noise = 16'($urandom);
			b = 8'($urandom);
			pending_words.push_back({noise, b});
		end
	endtask

	task automatic queue_random_frames(input int words);
		int target;
		int r;
		int len;
		logic [7:0] b;
		target = pending_words.size() + words;
		while (pending_words.size() < target) begin
			r = $urandom_range(0, 9);
			if (r == 0) len = 0;
			else if (r <= 6) len = $urandom_range(1, 4);
			else if (r <= 8) len = $urandom_range(5, 12);
			else len = $urandom_range(13, 40);
			b = 8'($urandom);
			queue_frame(len, b);
		end
	endtask

	task automatic drain_phase;
		while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (due_bytes.size() != 0) @(posedge clk);
	endtask

	// driver: hold a word until taken, then advance or idle; draw m_axis_tready at random
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (!s_axis_tvalid || in_hs) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tdata <= pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: check output words, then predict from accepted input words
	always @(posedge clk) begin
		framed_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		in_hs <= s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h", m_axis_tdata));
			end else begin
				want = due_bytes.pop_front();
				if (m_axis_tdata !== want.octet)
					report_mismatch($sformatf("byte %02h, want %02h", m_axis_tdata, want.octet));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
				if (m_axis_tuser !== want.fend)
					report_mismatch($sformatf("tuser %b, want %b", m_axis_tuser, want.fend));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			frame_predict(s_axis_tdata);
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 24'd0;
		m_axis_tready = 1'b0;
		in_hs = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		cycles = 0;
		pay_crc = CRC_INIT;
		left_count = 16'd0;
		framing = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		queue_frame(0, 8'hFF);
		queue_frame(0, 8'h00);
		queue_frame(1, 8'h00);
		queue_frame(1, 8'hFF);
		queue_frame(2, 8'hFF);
		queue_frame(3, 8'h00);
		queue_frame(0, 8'h5A);
		queue_random_frames(70);
		drain_phase();

		send_idle_pct = 84;
		recv_stall_pct = 0;
		queue_random_frames(70);
		drain_phase();

		send_idle_pct = 0;
		recv_stall_pct = 84;
		queue_random_frames(70);
		drain_phase();

		send_idle_pct = 27;
		recv_stall_pct = 27;
		queue_random_frames(70);
		drain_phase();

		// open a frame whose length field wraps; only its first word is sent
		pending_words.push_back({16'hFFFE, 8'hA5});
		drain_phase();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_bytes.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", due_bytes.size()));
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
